### rtl/core/rgba_box_downsample_2x2_top_macros.svh
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_TOP_MACROS_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define RBD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rbd assertion failed");

// next-cycle implication, disabled during reset
`define RBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rbd assertion failed");

`endif

### rtl/core/rbd_pkg.sv
package rbd_pkg;

   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int LINE_DEPTH = MAX_WIDTH / 2;

   localparam int SIZE_W    = 13;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int ROW_W     = $clog2(MAX_HEIGHT);
   localparam int X_W       = $clog2(LINE_DEPTH);
   localparam int Y_W       = ROW_W - 1;
   localparam int CH_W      = 8;
   localparam int SUM_W     = CH_W + 1;
   localparam int LANES     = 4;
   localparam int LINE_W    = LANES * SUM_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = CSR_IDX_W'(1);

   typedef struct packed {
      logic       vert;
      logic [1:0] shift;
      logic       last;
   } ctrl_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

### rtl/core/rbd_line_ram.sv
module rbd_line_ram #(
   parameter  int DEPTH = 2048,
   parameter  int WIDTH = 36,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/rbd_lane.sv
module rbd_lane (
   input  logic                       clock,
   input  logic [rbd_pkg::CH_W-1:0]   pix,
   input  logic [rbd_pkg::CH_W-1:0]   hold,
   input  logic                       wide,
   input  logic                       load,
   input  rbd_pkg::ctrl_type          ctrl,
   input  logic [rbd_pkg::SUM_W-1:0]  line,
   output logic [rbd_pkg::SUM_W-1:0]  hsum,
   output logic [rbd_pkg::CH_W-1:0]   avg
);

   logic [rbd_pkg::SUM_W-1:0] hs_in;
   logic [rbd_pkg::SUM_W-1:0] hs_ff;
   logic [rbd_pkg::SUM_W:0]   tot;
   logic [rbd_pkg::SUM_W:0]   shifted;

   always_comb begin
      if (wide) begin
         hs_in = {1'b0, hold} + {1'b0, pix};
      end else begin
         hs_in = {1'b0, pix};
      end
   end

   assign hsum = hs_in;

   always_ff @(posedge clock) begin
      if (load) begin
         hs_ff <= hs_in;
      end
   end

   always_comb begin
      if (ctrl.vert) begin
         tot = {1'b0, line} + {1'b0, hs_ff};
      end else begin
         tot = {1'b0, hs_ff};
      end
      shifted = tot >> ctrl.shift;
   end

   assign avg = shifted[rbd_pkg::CH_W-1:0];

endmodule

### rtl/core/rgba_box_downsample_2x2_top.sv
// 2x2 box-filter downsampler for RGBA8 raster frames. Takes one source pixel per clock while
// the output is not stalled and emits one half-size mip level (max(1,W/2) x max(1,H/2)) with
// rsp_tlast on its final pixel; odd last columns/rows are dropped and a 1x1 source produces
// nothing. The accepted source pixel that completes a block reaches its output word through
// the registered line-store read and then the output register. Four channel lanes add in
// parallel. The 2048 x 36 line store of horizontal pair sums is always written on an even row
// before the odd row reads it, so it needs no clearing pass. Sizes must be written on the csr
// port only while idle; the block itself does not enforce this. Any size write restarts the
// frame, 0 acts as 1 and values above 4096 saturate.
`include "rgba_box_downsample_2x2_top_macros.svh"

module rgba_box_downsample_2x2_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [31:0]                     req_tdata,  // in_red, in_green, in_blue, in_alpha
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [31:0]                     rsp_tdata,  // out_red, out_green, out_blue, out_alpha
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [rbd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbd_pkg::SIZE_W-1:0]      csr_wdata
);

   localparam int CH_W  = rbd_pkg::CH_W;
   localparam int SUM_W = rbd_pkg::SUM_W;
   localparam int LANES = rbd_pkg::LANES;

   logic [rbd_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [rbd_pkg::SIZE_W-1:0] height_ff, height_in;
   logic [rbd_pkg::COL_W-1:0]  col_ff, col_in;
   logic [rbd_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [LANES*CH_W-1:0]      hold_ff;
   logic                       p1_valid_ff, p1_valid_in;
   rbd_pkg::ctrl_type          p1_ctrl_ff, p1_ctrl_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [LANES*CH_W-1:0]      rsp_data_ff;
   logic                       rsp_last_ff;

   logic                       size_wr;
   logic                       wide, tall;
   logic                       col_ok, row_ok;
   logic [rbd_pkg::X_W-1:0]    x, ow_m1;
   logic [rbd_pkg::Y_W-1:0]    y, oh_m1;
   logic                       accept, active, have;
   logic                       emit, hold_ld, advance;
   logic                       ram_we, ram_re;
   logic [rbd_pkg::LINE_W-1:0] line_wdata, line_rdata;
   logic [SUM_W-1:0]           hsum [LANES];
   logic [CH_W-1:0]            avg  [LANES];
   logic [LANES*CH_W-1:0]      avg_word;

   // size registers hold clamped values
   assign size_wr = csr_we &&
                    ((csr_index == rbd_pkg::REG_SRC_WIDTH) ||
                     (csr_index == rbd_pkg::REG_SRC_HEIGHT));

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we && (csr_index == rbd_pkg::REG_SRC_WIDTH)) begin
         width_in = rbd_pkg::clamp_size(csr_wdata,
                                        rbd_pkg::SIZE_W'(rbd_pkg::MAX_WIDTH));
      end
      if (csr_we && (csr_index == rbd_pkg::REG_SRC_HEIGHT)) begin
         height_in = rbd_pkg::clamp_size(csr_wdata,
                                         rbd_pkg::SIZE_W'(rbd_pkg::MAX_HEIGHT));
      end
   end

   assign wide   = (width_ff != rbd_pkg::SIZE_W'(1));
   assign tall   = (height_ff != rbd_pkg::SIZE_W'(1));
   assign col_ok = !wide || ({1'b0, col_ff} < {width_ff[rbd_pkg::SIZE_W-1:1], 1'b0});
   assign row_ok = !tall || ({1'b0, row_ff} < {height_ff[rbd_pkg::SIZE_W-1:1], 1'b0});
   assign x      = wide ? col_ff[rbd_pkg::X_W:1] : '0;
   assign y      = tall ? row_ff[rbd_pkg::Y_W:1] : '0;
   assign ow_m1  = wide ? rbd_pkg::X_W'((width_ff >> 1) - rbd_pkg::SIZE_W'(1)) : '0;
   assign oh_m1  = tall ? rbd_pkg::Y_W'((height_ff >> 1) - rbd_pkg::SIZE_W'(1)) : '0;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !p1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign active     = accept && (wide || tall) && col_ok && row_ok;
   assign have       = !wide || col_ff[0];
   assign hold_ld    = active && wide && !col_ff[0];
   assign ram_we     = active && have && tall && !row_ff[0];
   assign emit       = active && have && (!tall || row_ff[0]);
   assign ram_re     = emit && tall;

   // raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (size_wr) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (({1'b0, col_ff} + rbd_pkg::SIZE_W'(1)) >= width_ff) begin
            col_in = '0;
            if (({1'b0, row_ff} + rbd_pkg::SIZE_W'(1)) >= height_ff) begin
               row_in = '0;
            end else begin
               row_in = row_ff + rbd_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + rbd_pkg::COL_W'(1);
         end
      end
   end

   always_comb begin
      p1_valid_in      = p1_valid_ff;
      p1_ctrl_in.vert  = tall;
      p1_ctrl_in.shift = {1'b0, wide} + {1'b0, tall};
      p1_ctrl_in.last  = (x == ow_m1) && (y == oh_m1);
      if (req_tready) begin
         p1_valid_in = emit;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= rbd_pkg::SIZE_W'(1);
         height_ff    <= rbd_pkg::SIZE_W'(1);
         col_ff       <= '0;
         row_ff       <= '0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_ld) begin
         hold_ff <= req_tdata;
      end
      if (emit) begin
         p1_ctrl_ff <= p1_ctrl_in;
      end
      if (advance && p1_valid_ff) begin
         rsp_data_ff <= avg_word;
         rsp_last_ff <= p1_ctrl_ff.last;
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      rbd_lane u_lane (
         .clock (clock),
         .pix   (req_tdata[l*CH_W +: CH_W]),
         .hold  (hold_ff[l*CH_W +: CH_W]),
         .wide  (wide),
         .load  (emit),
         .ctrl  (p1_ctrl_ff),
         .line  (line_rdata[l*SUM_W +: SUM_W]),
         .hsum  (hsum[l]),
         .avg   (avg[l])
      );
      assign line_wdata[l*SUM_W +: SUM_W] = hsum[l];
      assign avg_word[l*CH_W +: CH_W]     = avg[l];
   end

   rbd_line_ram #(
      .DEPTH (rbd_pkg::LINE_DEPTH),
      .WIDTH (rbd_pkg::LINE_W)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (x),
      .wdata (line_wdata),
      .re    (ram_re),
      .raddr (x),
      .rdata (line_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `RBD_ASSERT_NOW(a_ram_excl, clock, reset, ram_we, !ram_re)
   `RBD_ASSERT_NEXT(a_cfg_restart, clock, reset, size_wr, (col_ff == '0) && (row_ff == '0))
   `RBD_ASSERT_NOW(a_stall_blocks, clock, reset, p1_valid_ff && rsp_valid_ff && !rsp_tready, !req_tready)
   `RBD_ASSERT_NEXT(a_single_quiet, clock, reset, !wide && !tall && !p1_valid_ff && !size_wr, !p1_valid_ff)

endmodule
